/* hw/rtl/gfcd_pkg.sv */
// shared types, constants and helper functions of the gated frequency counter display
`default_nettype none
package gfcd_pkg;

  // pulse counter width default
  localparam int COUNT_BITS_DEF = 24;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GATE_TICKS   = 4'd0,
    REG_LED_ON_TICKS = 4'd1,
    REG_LED_OFF_END  = 4'd2,
    REG_KHZ_MODE     = 4'd3
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] GATE_TICKS_RST   = 16'd1000;
  localparam logic [CFG_W-1:0] LED_ON_TICKS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] LED_OFF_END_RST  = 16'd2000;

  // display geometry
  localparam int MEAS_W     = 24;
  localparam int SEG_W      = 8;
  localparam int NUM_POS    = 8;
  localparam int POS_W      = $clog2(NUM_POS);
  localparam int NUM_DIGITS = 6;
  localparam int DP_POS     = 3;
  localparam logic [SEG_W-1:0] DP_MASK = 8'h80;

  // largest value the six digits can show
  localparam int DISP_MAX = 999999;
  localparam int BIN_W    = 20;

  // binary to bcd conversion pipeline
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int DD_W       = BCD_W + BIN_W;
  localparam int DD_PER_STG = 4;
  localparam int DD_STAGES  = BIN_W / DD_PER_STG;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // what a tick does to the segment store
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_SHOW  = 2'd1,
    OP_CLEAR = 2'd2
  } disp_op_e;

  typedef struct packed {
    disp_op_e           op;
    logic               lamp;
    logic [POS_W-1:0]   scan;
    logic               khz;
    logic [BIN_W-1:0]   value;
    logic [MEAS_W-1:0]  measured;
  } q_entry_t;

  function automatic logic [SEG_W-1:0] glyph(input logic [3:0] digit);
    logic [SEG_W-1:0] code;
    unique case (digit)
      4'h0: code = 8'h3F;
      4'h1: code = 8'h06;
      4'h2: code = 8'h5B;
      4'h3: code = 8'h4F;
      4'h4: code = 8'h66;
      4'h5: code = 8'h6D;
      4'h6: code = 8'h7D;
      4'h7: code = 8'h07;
      4'h8: code = 8'h7F;
      4'h9: code = 8'h6F;
      4'hA: code = 8'h77;
      4'hB: code = 8'h7C;
      4'hC: code = 8'h39;
      4'hD: code = 8'h5E;
      4'hE: code = 8'h79;
      4'hF: code = 8'h71;
      default: code = '0;
    endcase
    return code;
  endfunction

  // four shift-and-add-3 steps of the double dabble conversion
  function automatic logic [DD_W-1:0] dd_step(input logic [DD_W-1:0] x);
    logic [DD_W-1:0] y;
    y = x;
    for (int s = 0; s < DD_PER_STG; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (y[BIN_W+4*d +: 4] >= 4'd5) begin
          y[BIN_W+4*d +: 4] = y[BIN_W+4*d +: 4] + 4'd3;
        end
      end
      y = {y[DD_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/gated_frequency_counter_display_unit.sv */
// top level of the gated frequency counter with seven-segment scan output
`default_nettype none
// Gated frequency counter with an eight-position seven-segment scan buffer.
// Every input transaction carries a pulse flag and a millisecond tick flag;
// one transaction is taken per clock while in_ready_o is high, and only
// transactions with the tick flag set produce a result transaction (lamp,
// scanned position, segment pattern of that position, latched count). The
// front counts pulses and ticks and decides per tick whether the six
// digits are rewritten, cleared or left alone; a four-entry queue hands
// tick transactions to the back, which converts the saturated count to
// decimal in a five-stage shift-and-add-3 pipeline (four bits per stage),
// updates the segment store and loads the output register. A tick
// transaction passes through the queue, the conversion stages and then
// the output register; sustained rate is one transaction per clock while
// the output side takes one per clock. When the output stalls, the pipe
// holds and the queue fills, after which in_ready_o drops.
// Configuration writes are always taken (cfg_ready_o is tied high); an
// index beyond the four registers is ignored.
module gated_frequency_counter_display_unit #(
  parameter int COUNT_BITS = gfcd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gfcd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gfcd_pkg::CFG_W-1:0]     cfg_data_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           pulse_i,
  input  logic                           tick_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           lamp_on_o,
  output logic [gfcd_pkg::POS_W-1:0]     digit_select_o,
  output logic [gfcd_pkg::SEG_W-1:0]     segments_o,
  output logic [gfcd_pkg::MEAS_W-1:0]    measured_count_o
);

  logic               accept;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  gfcd_pkg::q_entry_t front_entry;
  gfcd_pkg::q_entry_t q_entry;

  // registers can be written at any time
  assign cfg_ready_o = 1'b1;

  // only a full queue holds off the input side
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // counters, lamp timing and classification of each tick
  gfcd_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pulse_i     (pulse_i),
    .tick_i      (tick_i),
    .push_o      (push),
    .entry_o     (front_entry)
  );

  // decouples tick classification from the conversion pipe
  gfcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // decimal conversion, segment store and result register
  gfcd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_entry_i        (q_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .lamp_on_o        (lamp_on_o),
    .digit_select_o   (digit_select_o),
    .segments_o       (segments_o),
    .measured_count_o (measured_count_o)
  );

endmodule
`default_nettype wire

/* hw/rtl/gfcd_front.sv */
// front end: configuration registers, pulse and tick counters, tick classification
`default_nettype none
module gfcd_front #(
  parameter int COUNT_BITS = gfcd_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [gfcd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gfcd_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                            accept_i,
  input  logic                            pulse_i,
  input  logic                            tick_i,
  output logic                            push_o,
  output gfcd_pkg::q_entry_t              entry_o
);

  logic [gfcd_pkg::CFG_W-1:0] gate_ticks_q, led_on_ticks_q, led_off_end_q;
  logic                       khz_mode_q;

  logic [COUNT_BITS-1:0]      pulse_total_q, pulse_total_d;
  logic [COUNT_BITS-1:0]      latched_total_q, latched_total_d;
  logic [gfcd_pkg::CFG_W-1:0] gate_elapsed_q, gate_elapsed_d;
  logic [gfcd_pkg::CFG_W-1:0] lamp_elapsed_q, lamp_elapsed_d;
  logic [gfcd_pkg::POS_W-1:0] scan_q, scan_d;
  logic                       lamp_q, lamp_d;
  gfcd_pkg::disp_op_e         op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_ticks_q   <= gfcd_pkg::GATE_TICKS_RST;
      led_on_ticks_q <= gfcd_pkg::LED_ON_TICKS_RST;
      led_off_end_q  <= gfcd_pkg::LED_OFF_END_RST;
      khz_mode_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (gfcd_pkg::cfg_reg_e'(cfg_index_i))
        gfcd_pkg::REG_GATE_TICKS:   gate_ticks_q   <= cfg_data_i;
        gfcd_pkg::REG_LED_ON_TICKS: led_on_ticks_q <= cfg_data_i;
        gfcd_pkg::REG_LED_OFF_END:  led_off_end_q  <= cfg_data_i;
        gfcd_pkg::REG_KHZ_MODE:     khz_mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pulse_total_d   = pulse_total_q;
    latched_total_d = latched_total_q;
    gate_elapsed_d  = gate_elapsed_q;
    lamp_elapsed_d  = lamp_elapsed_q;
    scan_d          = scan_q;
    lamp_d          = lamp_q;
    op              = gfcd_pkg::OP_HOLD;

    // saturating pulse count, taken before the tick
    if (pulse_i && (pulse_total_q != {COUNT_BITS{1'b1}})) begin
      pulse_total_d = pulse_total_q + COUNT_BITS'(1);
    end

    if (tick_i) begin
      gate_elapsed_d = gate_elapsed_q + gfcd_pkg::CFG_W'(1);
      lamp_elapsed_d = lamp_elapsed_q + gfcd_pkg::CFG_W'(1);
      scan_d         = scan_q + gfcd_pkg::POS_W'(1);

      if (gate_elapsed_d >= gate_ticks_q) begin
        gate_elapsed_d  = '0;
        latched_total_d = pulse_total_d;
        pulse_total_d   = '0;
      end

      if (lamp_elapsed_d < led_on_ticks_q) begin
        lamp_d = 1'b1;
      end else if (lamp_elapsed_d <= led_off_end_q) begin
        lamp_d = 1'b0;
        op     = gfcd_pkg::OP_SHOW;
      end else begin
        lamp_elapsed_d = '0;
        op             = gfcd_pkg::OP_CLEAR;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_total_q   <= '0;
      latched_total_q <= '0;
      gate_elapsed_q  <= '0;
      lamp_elapsed_q  <= '0;
      scan_q          <= '0;
      lamp_q          <= 1'b0;
    end else if (accept_i) begin
      pulse_total_q   <= pulse_total_d;
      latched_total_q <= latched_total_d;
      gate_elapsed_q  <= gate_elapsed_d;
      lamp_elapsed_q  <= lamp_elapsed_d;
      scan_q          <= scan_d;
      lamp_q          <= lamp_d;
    end
  end

  assign push_o = accept_i && tick_i;

  always_comb begin
    entry_o.op       = op;
    entry_o.lamp     = lamp_d;
    entry_o.scan     = scan_q;
    entry_o.khz      = khz_mode_q;
    entry_o.measured = gfcd_pkg::MEAS_W'(latched_total_d);
    // clamp to what six digits can show
    if (latched_total_d > COUNT_BITS'(gfcd_pkg::DISP_MAX)) begin
      entry_o.value = gfcd_pkg::BIN_W'(gfcd_pkg::DISP_MAX);
    end else begin
      entry_o.value = latched_total_d[gfcd_pkg::BIN_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gfcd_queue.sv */
// short fifo of tick transactions between front and back
`default_nettype none
module gfcd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gfcd_pkg::q_entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output gfcd_pkg::q_entry_t entry_o
);

  gfcd_pkg::q_entry_t              mem_q [gfcd_pkg::QUEUE_DEPTH];
  logic [gfcd_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [gfcd_pkg::QCNT_W-1:0]     cnt_q;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == gfcd_pkg::QCNT_W'(gfcd_pkg::QUEUE_DEPTH));
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == gfcd_pkg::QPTR_W'(gfcd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == gfcd_pkg::QPTR_W'(gfcd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/gfcd_back.sv */
// back end: pipelined bcd conversion, segment store update and output register
`default_nettype none
module gfcd_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  gfcd_pkg::q_entry_t            q_entry_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          lamp_on_o,
  output logic [gfcd_pkg::POS_W-1:0]    digit_select_o,
  output logic [gfcd_pkg::SEG_W-1:0]    segments_o,
  output logic [gfcd_pkg::MEAS_W-1:0]   measured_count_o
);

  localparam int NSTG = gfcd_pkg::DD_STAGES;

  gfcd_pkg::q_entry_t          ent_q  [NSTG];
  logic [gfcd_pkg::DD_W-1:0]   dd_q   [NSTG];
  logic [NSTG-1:0]             vld_q;

  logic [gfcd_pkg::SEG_W-1:0]  store_q [gfcd_pkg::NUM_POS];
  logic [gfcd_pkg::SEG_W-1:0]  store_d [gfcd_pkg::NUM_POS];
  logic [gfcd_pkg::BCD_W-1:0]  bcd;
  gfcd_pkg::q_entry_t          last;

  logic                        out_valid_q;
  logic                        en;

  // whole pipe moves when the output register can take a transaction
  assign en      = !out_valid_q || out_ready_i;
  assign q_pop_o = en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q[0] <= q_valid_i;
      for (int i = 1; i < NSTG; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q[0] <= q_entry_i;
      dd_q[0]  <= gfcd_pkg::dd_step(gfcd_pkg::DD_W'(q_entry_i.value));
      for (int i = 1; i < NSTG; i++) begin
        ent_q[i] <= ent_q[i-1];
        dd_q[i]  <= gfcd_pkg::dd_step(dd_q[i-1]);
      end
    end
  end

  assign last = ent_q[NSTG-1];
  assign bcd  = dd_q[NSTG-1][gfcd_pkg::DD_W-1 -: gfcd_pkg::BCD_W];

  always_comb begin
    store_d = store_q;
    if (vld_q[NSTG-1]) begin
      unique case (last.op)
        gfcd_pkg::OP_HOLD: ;
        gfcd_pkg::OP_SHOW: begin
          for (int i = 0; i < gfcd_pkg::NUM_DIGITS; i++) begin
            store_d[i] = gfcd_pkg::glyph(bcd[4*i +: 4]);
          end
          if (last.khz) begin
            store_d[gfcd_pkg::DP_POS] = store_d[gfcd_pkg::DP_POS] | gfcd_pkg::DP_MASK;
          end
        end
        gfcd_pkg::OP_CLEAR: begin
          store_d[0] = gfcd_pkg::glyph(4'd0);
          store_d[1] = gfcd_pkg::glyph(4'd0);
          for (int i = 2; i < gfcd_pkg::NUM_POS; i++) begin
            store_d[i] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gfcd_pkg::NUM_POS; i++) begin
        store_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      store_q     <= store_d;
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NSTG-1]) begin
      lamp_on_o        <= last.lamp;
      digit_select_o   <= last.scan;
      segments_o       <= store_d[last.scan];
      measured_count_o <= last.measured;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
